### hw/rtl/lgts_pkg.sv
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler package
// Shared sizes, request codes, csr indices and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package lgts_pkg;

   localparam int NUM_TOPICS = 64;
   localparam int TOPIC_BITS = 6;
   localparam int VOCAB_SIZE = 4096;
   localparam int WORD_BITS  = 12;
   localparam int COUNT_BITS = 24;
   localparam int DOC_BITS   = 16;
   localparam int WEIGHT_BITS = 48;
   localparam int SUM_BITS   = WEIGHT_BITS + TOPIC_BITS;
   localparam int A_BITS     = 33;
   localparam int B_BITS     = 41;
   localparam int PROD_BITS  = A_BITS + B_BITS;
   localparam int ACC_BITS   = SUM_BITS + 32;
   localparam int REM_BITS   = B_BITS + 1;
   localparam int CNT_BITS   = 7;
   localparam int KCNT_BITS  = 7;
   localparam int MUL_STEPS  = A_BITS;
   localparam int DIV_STEPS  = PROD_BITS;

   localparam logic [2:0] REQ_LOAD_WORD  = 3'd0;
   localparam logic [2:0] REQ_LOAD_TOTAL = 3'd1;
   localparam logic [2:0] REQ_START_DOC  = 3'd2;
   localparam logic [2:0] REQ_ADD_TOKEN  = 3'd3;
   localparam logic [2:0] REQ_RESAMPLE   = 3'd4;
   localparam logic [2:0] REQ_READ_WORD  = 3'd5;
   localparam logic [2:0] REQ_READ_TOTAL = 3'd6;

   localparam logic [1:0] CSR_BETA       = 2'd0;
   localparam logic [1:0] CSR_BETA_TOTAL = 2'd1;
   localparam logic [1:0] CSR_TOPICS     = 2'd2;

   typedef enum logic [14:0] {
      ST_IDLE = 15'b000000000000001,
      ST_READ = 15'b000000000000010,
      ST_USE  = 15'b000000000000100,
      ST_WRD  = 15'b000000000001000,
      ST_WLD  = 15'b000000000010000,
      ST_WMUL = 15'b000000000100000,
      ST_WDIV = 15'b000000001000000,
      ST_WWR  = 15'b000000010000000,
      ST_SMUL = 15'b000000100000000,
      ST_KRD  = 15'b000001000000000,
      ST_KCMP = 15'b000010000000000,
      ST_IRD  = 15'b000100000000000,
      ST_IWR  = 15'b001000000000000,
      ST_DONE = 15'b010000000000000,
      ST_SPARE = 15'b100000000000000
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/lgts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle for write and read, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lgts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/lda_gibbs_topic_sampler.sv
// ----------------------------------------------------------------------------
// LDA Gibbs topic sampler
// Collapsed Gibbs sampling step over RAM-held count tables.
// ----------------------------------------------------------------------------
// A request beat is taken when req_valid is high and req_stall is low; every
// request gives exactly one response beat, taken when rsp_valid is high and
// rsp_stall is low. The block works on one request at a time and holds
// req_stall high while busy. A load or start-document request passes through
// the read and done states, and a read or add-token request also through the
// use state. A resample runs one shared shift-add multiplier and restoring
// divider for each active topic K: 33 multiply steps and 74 divide steps plus
// the table read, load and write states per topic, then 33 steps to scale the
// random number and a read and compare state per topic of the walk, which
// stops at the chosen topic. The response sits in an output register; a
// stalled receiver holds it there, and the next request may be taken
// meanwhile but cannot finish until the register is free. Configuration
// beats on the csr channel are always taken. Reset returns the sequencer to
// idle, drops the response, sets the csr registers to their defaults and
// empties the document counts; the count, total, alpha and weight tables are
// undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module lda_gibbs_topic_sampler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [11:0] req_word_id,
   input  wire logic [5:0]  req_topic_in,
   input  wire logic [23:0] req_count_value,
   input  wire logic [31:0] req_alpha_value,
   input  wire logic [31:0] req_uniform,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_new_topic,
   output logic [23:0]      rsp_read_value,
   output logic             rsp_count_underflow,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int TB = lgts_pkg::TOPIC_BITS;
   localparam int CB = lgts_pkg::COUNT_BITS;
   localparam int DB = lgts_pkg::DOC_BITS;
   localparam int WB = lgts_pkg::WEIGHT_BITS;

   lgts_pkg::state_type state_ff, state_in;

   logic [31:0] beta_ff, beta_total_ff;
   logic [6:0]  topics_ff;

   logic [2:0]  type_ff;
   logic [lgts_pkg::WORD_BITS-1:0] word_ff;
   logic [TB-1:0] t_ff, t_in;
   logic [CB-1:0] count_ff;
   logic [31:0] alpha_ff, uni_ff;

   logic [lgts_pkg::A_BITS-1:0]   a_ff, a_in;
   logic [lgts_pkg::ACC_BITS-1:0] b_ff, b_in;
   logic [lgts_pkg::ACC_BITS-1:0] prod_ff, prod_in;
   logic [lgts_pkg::REM_BITS-1:0] rem_ff, rem_in;
   logic [lgts_pkg::B_BITS-1:0]   d_ff, d_in;
   logic [lgts_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [lgts_pkg::SUM_BITS-1:0] sum_ff, sum_in, target_ff, target_in;
   logic [CB-1:0] readv_ff, readv_in;
   logic          under_ff, under_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [TB-1:0] out_topic_ff, out_topic_in;
   logic [CB-1:0] out_read_ff, out_read_in;
   logic          out_under_ff, out_under_in;

   logic [lgts_pkg::NUM_TOPICS-1:0] doc_vld_ff, doc_vld_in;
   logic          doc_vq_ff;

   logic          wtc_we, tot_we, alp_we, doc_we, wgt_we;
   logic [CB-1:0] wtc_wd, tot_wd, wtc_rd, tot_rd;
   logic [31:0]   alp_rd;
   logic [DB-1:0] doc_wd, doc_rd, docv;
   logic [WB-1:0] wgt_wd, wgt_rd;

   logic [6:0]    k_clamp;
   logic [TB-1:0] last_topic;
   logic [lgts_pkg::REM_BITS-1:0] rem_sh;
   logic          q_bit;
   logic [WB-1:0] weight;
   logic          accept;

   lgts_ram #(.WIDTH(CB), .DEPTH(lgts_pkg::NUM_TOPICS * lgts_pkg::VOCAB_SIZE)) u_wtc (
      .clock(clock), .wr_en(wtc_we), .addr({word_ff, t_ff}), .wr_data(wtc_wd),
      .rd_data(wtc_rd));
   lgts_ram #(.WIDTH(CB), .DEPTH(lgts_pkg::NUM_TOPICS)) u_tot (
      .clock(clock), .wr_en(tot_we), .addr(t_ff), .wr_data(tot_wd), .rd_data(tot_rd));
   lgts_ram #(.WIDTH(32), .DEPTH(lgts_pkg::NUM_TOPICS)) u_alp (
      .clock(clock), .wr_en(alp_we), .addr(t_ff), .wr_data(alpha_ff), .rd_data(alp_rd));
   lgts_ram #(.WIDTH(DB), .DEPTH(lgts_pkg::NUM_TOPICS)) u_doc (
      .clock(clock), .wr_en(doc_we), .addr(t_ff), .wr_data(doc_wd), .rd_data(doc_rd));
   lgts_ram #(.WIDTH(WB), .DEPTH(lgts_pkg::NUM_TOPICS)) u_wgt (
      .clock(clock), .wr_en(wgt_we), .addr(t_ff), .wr_data(wgt_wd), .rd_data(wgt_rd));

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != lgts_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_new_topic = out_topic_ff;
   assign rsp_read_value = out_read_ff;
   assign rsp_count_underflow = out_under_ff;

   assign docv = doc_vq_ff ? doc_rd : '0;
   assign rem_sh = {rem_ff[lgts_pkg::REM_BITS-2:0], prod_ff[lgts_pkg::PROD_BITS-1]};
   assign q_bit  = (rem_sh >= {1'b0, d_ff});
   assign weight = ((d_ff == '0) || (prod_ff[lgts_pkg::PROD_BITS-1:WB] != '0)) ?
                   {WB{1'b1}} : prod_ff[WB-1:0];

   always_comb begin
      if (topics_ff == 7'd0) begin
         k_clamp = 7'd1;
      end else if (topics_ff > 7'(lgts_pkg::NUM_TOPICS)) begin
         k_clamp = 7'(lgts_pkg::NUM_TOPICS);
      end else begin
         k_clamp = topics_ff;
      end
      last_topic = TB'(k_clamp - 7'd1);
   end

   always_comb begin
      state_in = state_ff;
      t_in = t_ff;
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      target_in = target_ff;
      readv_in = readv_ff;
      under_in = under_ff;
      doc_vld_in = doc_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_topic_in = out_topic_ff;
      out_read_in = out_read_ff;
      out_under_in = out_under_ff;
      wtc_we = 1'b0;
      tot_we = 1'b0;
      alp_we = 1'b0;
      doc_we = 1'b0;
      wgt_we = 1'b0;
      wtc_wd = count_ff;
      tot_wd = count_ff;
      doc_wd = docv;
      wgt_wd = weight;

      unique case (state_ff)
         lgts_pkg::ST_IDLE: begin
            if (accept) begin
               t_in = req_topic_in;
               readv_in = '0;
               under_in = 1'b0;
               state_in = lgts_pkg::ST_READ;
            end
         end
         lgts_pkg::ST_READ: begin
            priority case (type_ff)
               lgts_pkg::REQ_LOAD_WORD: begin
                  wtc_we = 1'b1;
                  state_in = lgts_pkg::ST_DONE;
               end
               lgts_pkg::REQ_LOAD_TOTAL: begin
                  tot_we = 1'b1;
                  alp_we = 1'b1;
                  state_in = lgts_pkg::ST_DONE;
               end
               lgts_pkg::REQ_START_DOC: begin
                  doc_vld_in = '0;
                  state_in = lgts_pkg::ST_DONE;
               end
               lgts_pkg::REQ_ADD_TOKEN, lgts_pkg::REQ_RESAMPLE,
               lgts_pkg::REQ_READ_WORD, lgts_pkg::REQ_READ_TOTAL: begin
                  state_in = lgts_pkg::ST_USE;
               end
               default: begin
                  state_in = lgts_pkg::ST_DONE;
               end
            endcase
         end
         lgts_pkg::ST_USE: begin
            state_in = lgts_pkg::ST_DONE;
            priority case (type_ff)
               lgts_pkg::REQ_ADD_TOKEN: begin
                  doc_we = 1'b1;
                  doc_wd = (&docv) ? docv : docv + 1'b1;
                  doc_vld_in[t_ff] = 1'b1;
               end
               lgts_pkg::REQ_RESAMPLE: begin
                  doc_we = 1'b1;
                  wtc_we = 1'b1;
                  tot_we = 1'b1;
                  doc_wd = (docv == '0) ? '0 : docv - 1'b1;
                  wtc_wd = (wtc_rd == '0) ? '0 : wtc_rd - 1'b1;
                  tot_wd = (tot_rd == '0) ? '0 : tot_rd - 1'b1;
                  doc_vld_in[t_ff] = 1'b1;
                  under_in = (docv == '0) || (wtc_rd == '0) || (tot_rd == '0);
                  t_in = '0;
                  sum_in = '0;
                  state_in = lgts_pkg::ST_WRD;
               end
               lgts_pkg::REQ_READ_WORD: begin
                  readv_in = wtc_rd;
               end
               default: begin
                  readv_in = tot_rd;
               end
            endcase
         end
         lgts_pkg::ST_WRD: begin
            state_in = lgts_pkg::ST_WLD;
         end
         lgts_pkg::ST_WLD: begin
            a_in = {1'b0, alp_rd} + {1'b0, docv, 16'd0};
            b_in = lgts_pkg::ACC_BITS'({9'd0, beta_ff} + {1'b0, wtc_rd, 16'd0});
            d_in = {9'd0, beta_total_ff} + {1'b0, tot_rd, 16'd0};
            prod_in = '0;
            cnt_in = '0;
            state_in = lgts_pkg::ST_WMUL;
         end
         lgts_pkg::ST_WMUL, lgts_pkg::ST_SMUL: begin
            prod_in = prod_ff + (a_ff[0] ? b_ff : '0);
            a_in = a_ff >> 1;
            b_in = b_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lgts_pkg::CNT_BITS'(lgts_pkg::MUL_STEPS - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               if (state_ff == lgts_pkg::ST_WMUL) begin
                  state_in = lgts_pkg::ST_WDIV;
               end else begin
                  target_in = prod_in[lgts_pkg::ACC_BITS-1:32];
                  t_in = '0;
                  state_in = lgts_pkg::ST_KRD;
               end
            end
         end
         lgts_pkg::ST_WDIV: begin
            rem_in = q_bit ? rem_sh - {1'b0, d_ff} : rem_sh;
            prod_in = {{(lgts_pkg::ACC_BITS - lgts_pkg::PROD_BITS){1'b0}},
                       prod_ff[lgts_pkg::PROD_BITS-2:0], q_bit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lgts_pkg::CNT_BITS'(lgts_pkg::DIV_STEPS - 1)) begin
               state_in = lgts_pkg::ST_WWR;
            end
         end
         lgts_pkg::ST_WWR: begin
            wgt_we = 1'b1;
            sum_in = sum_ff + lgts_pkg::SUM_BITS'(weight);
            if (t_ff == last_topic) begin
               a_in = {1'b0, uni_ff};
               b_in = lgts_pkg::ACC_BITS'(sum_in);
               prod_in = '0;
               cnt_in = '0;
               state_in = lgts_pkg::ST_SMUL;
            end else begin
               t_in = t_ff + 1'b1;
               state_in = lgts_pkg::ST_WRD;
            end
         end
         lgts_pkg::ST_KRD: begin
            state_in = lgts_pkg::ST_KCMP;
         end
         lgts_pkg::ST_KCMP: begin
            if ((t_ff != last_topic) && (target_ff > lgts_pkg::SUM_BITS'(wgt_rd))) begin
               target_in = target_ff - lgts_pkg::SUM_BITS'(wgt_rd);
               t_in = t_ff + 1'b1;
               state_in = lgts_pkg::ST_KRD;
            end else begin
               state_in = lgts_pkg::ST_IRD;
            end
         end
         lgts_pkg::ST_IRD: begin
            state_in = lgts_pkg::ST_IWR;
         end
         lgts_pkg::ST_IWR: begin
            doc_we = 1'b1;
            wtc_we = 1'b1;
            tot_we = 1'b1;
            doc_wd = (&docv) ? docv : docv + 1'b1;
            wtc_wd = (&wtc_rd) ? wtc_rd : wtc_rd + 1'b1;
            tot_wd = (&tot_rd) ? tot_rd : tot_rd + 1'b1;
            doc_vld_in[t_ff] = 1'b1;
            state_in = lgts_pkg::ST_DONE;
         end
         lgts_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_topic_in = (type_ff == lgts_pkg::REQ_RESAMPLE) ? t_ff : '0;
               out_read_in = readv_ff;
               out_under_in = under_ff;
               state_in = lgts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lgts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         doc_vld_ff <= '0;
         beta_ff <= 32'd655;
         beta_total_ff <= 32'd65536;
         topics_ff <= 7'd64;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         doc_vld_ff <= doc_vld_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lgts_pkg::CSR_BETA:       beta_ff <= csr_wdata;
               lgts_pkg::CSR_BETA_TOTAL: beta_total_ff <= csr_wdata;
               lgts_pkg::CSR_TOPICS:     topics_ff <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         word_ff <= req_word_id;
         count_ff <= req_count_value;
         alpha_ff <= req_alpha_value;
         uni_ff <= req_uniform;
      end
      t_ff <= t_in;
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      sum_ff <= sum_in;
      target_ff <= target_in;
      readv_ff <= readv_in;
      under_ff <= under_in;
      out_topic_ff <= out_topic_in;
      out_read_ff <= out_read_in;
      out_under_ff <= out_under_in;
      doc_vq_ff <= doc_vld_in[t_in] && doc_vld_ff[t_in];
   end

endmodule

`default_nettype wire
